### hdl/suc_pkg.sv
// Shared types and constants of the sorted unique colour set unit.
// Holds request codes, result status codes and the per-cell control structs.
// No dependencies.
`default_nettype none
package suc_pkg;

  localparam int COLOUR_W = 16;
  localparam int INDEX_W  = 4;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_READ_OK   = 3'd5,
    ST_RANGE     = 3'd6
  } status_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic                insert;
    logic [COLOUR_W-1:0] colour;
  } cell_ctl_t;

  // Per-cell position info computed by the top level.
  typedef struct packed {
    logic occupied;
    logic rd_sel;
  } cell_pos_t;

  // Compare results a cell reports.
  typedef struct packed {
    logic above;
    logic eq;
  } cell_stat_t;

endpackage
`default_nettype wire

### hdl/suc_cell.sv
// One storage cell of the sorted colour chain: holds one entry.
// Compares against the broadcast colour; on insert takes its left neighbor's entry or the broadcast colour.
// Depends on suc_pkg.
`default_nettype none
module suc_cell
  import suc_pkg::*;
(
  input  wire logic                clk,
  input  wire cell_ctl_t           ctl,
  input  wire cell_pos_t           pos,
  input  wire logic                left_above,
  input  wire logic [COLOUR_W-1:0] left_entry,
  output      cell_stat_t          stat,
  output      logic [COLOUR_W-1:0] entry,
  output      logic [COLOUR_W-1:0] rd_data
);

  logic [COLOUR_W-1:0] entry_r;
  logic [COLOUR_W-1:0] entry_nxt;

  always_comb begin
    stat.above = !pos.occupied || (entry_r >= ctl.colour);
    stat.eq    = pos.occupied && (entry_r == ctl.colour);
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.insert) begin
      if (left_above) begin
        entry_nxt = left_entry;
      end else if (stat.above) begin
        entry_nxt = ctl.colour;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry   = entry_r;
  assign rd_data = (pos.rd_sel && pos.occupied) ? entry_r : '0;

endmodule
`default_nettype wire

### hdl/sorted_unique_colour_set_unit.sv
// Top level of the sorted unique colour set unit.
// Instantiates a row of suc_cell and registers the result. Depends on suc_pkg.
//
// Usage:
//   Input channel: a request is taken at a rising edge with start high and busy
//   low. busy stays low: every cycle can carry a request. in_command selects add
//   (insert in ascending order), look up, or read entry at in_index (codes 2 and
//   3 both read).
//   Result channel: one result per request, shown for exactly one cycle with
//   out_valid high, on the cycle right after the request is taken. It carries the
//   status, the count after the request, and the entry read (zero otherwise).
//   Throughput is 1 request per cycle: all CAPACITY cells
//   compare the broadcast colour in parallel and shift by one in the same cycle,
//   so the next request sees the updated set.
//   Reset (rst_n low at a clock edge) empties the set and drops any pending
//   result. The receiver cannot stall; results must be taken when shown.
//   Reads reach only the first 16 positions, the range of in_index.
`default_nettype none
module sorted_unique_colour_set_unit
  import suc_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic [CMD_W-1:0]    in_command,
  input  wire logic [COLOUR_W-1:0] in_colour,
  input  wire logic [INDEX_W-1:0]  in_index,
  output      logic                out_valid,
  output      logic [STATUS_W-1:0] out_status,
  output      logic [CNT_W-1:0]    out_count,
  output      logic [COLOUR_W-1:0] out_colour_out
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  status_t             status_r;
  status_t             status_nxt;
  logic [CNT_W-1:0]    out_count_r;
  logic [COLOUR_W-1:0] colour_out_r;
  logic [COLOUR_W-1:0] colour_out_nxt;

  cell_ctl_t           ctl;
  cell_pos_t           pos   [CAPACITY];
  cell_stat_t          stat  [CAPACITY];
  logic [COLOUR_W-1:0] entry [CAPACITY];
  logic [COLOUR_W-1:0] rd    [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] hit_vec;

  logic                accept;
  logic                is_add;
  logic                is_lookup;
  logic                present;
  logic                full;
  logic                rd_hit;
  logic [COLOUR_W-1:0] rd_word;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    is_add    = 1'b0;
    is_lookup = 1'b0;
    unique case (cmd_t'(in_command))
      CMD_ADD:    is_add    = 1'b1;
      CMD_LOOKUP: is_lookup = 1'b1;
      default:    ;
    endcase
  end

  assign present    = |eq_vec;
  assign full       = (count_r == CAP_CNT);
  assign ctl.colour = in_colour;
  assign ctl.insert = accept && is_add && !present && !full;

  genvar k;
  generate
    for (k = 0; k < CAPACITY; k++) begin : g_cell
      assign pos[k].occupied = (k < int'(count_r));
      assign pos[k].rd_sel   = (int'(in_index) == k);
      assign eq_vec[k]       = stat[k].eq;
      assign hit_vec[k]      = pos[k].occupied && pos[k].rd_sel;

      if (k == 0) begin : g_head
        suc_cell u_cell (
          .clk        (clk),
          .ctl        (ctl),
          .pos        (pos[k]),
          .left_above (1'b0),
          .left_entry ({COLOUR_W{1'b0}}),
          .stat       (stat[k]),
          .entry      (entry[k]),
          .rd_data    (rd[k])
        );
      end else begin : g_body
        suc_cell u_cell (
          .clk        (clk),
          .ctl        (ctl),
          .pos        (pos[k]),
          .left_above (stat[k-1].above),
          .left_entry (entry[k-1]),
          .stat       (stat[k]),
          .entry      (entry[k]),
          .rd_data    (rd[k])
        );
      end
    end
  endgenerate

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | rd[i];
    end
  end

  assign rd_hit = |hit_vec;

  always_comb begin
    count_nxt      = count_r + CNT_W'(ctl.insert);
    out_valid_nxt  = accept;
    colour_out_nxt = '0;
    if (is_add) begin
      if (present) begin
        status_nxt = ST_PRESENT;
      end else if (full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_ADDED;
      end
    end else if (is_lookup) begin
      status_nxt = present ? ST_FOUND : ST_NOT_FOUND;
    end else if (rd_hit) begin
      status_nxt     = ST_READ_OK;
      colour_out_nxt = rd_word;
    end else begin
      status_nxt = ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status_nxt;
      out_count_r  <= count_nxt;
      colour_out_r <= colour_out_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_count      = out_count_r;
  assign out_colour_out = colour_out_r;

endmodule
`default_nettype wire

### hdl/suc_checker.sv
// Port-level checker for the sorted unique colour set unit, bound to the top level.
// Depends on suc_pkg and sorted_unique_colour_set_unit.
`default_nettype none
module suc_checker
  import suc_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [CNT_W-1:0]    out_count,
  input wire logic [COLOUR_W-1:0] out_colour_out
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("item accepted without a result next cycle");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without an accepted item");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_count) <= CAPACITY))
    else $error("count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && $past(rst_n)) |->
      (out_count == $past(out_count) ||
       out_count == CNT_W'($past(out_count) + CNT_W'(1))))
    else $error("count moved by more than one item");

  a_colour_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_READ_OK) |-> (out_colour_out == '0))
    else $error("nonzero colour on a result that is not a read");

endmodule

bind sorted_unique_colour_set_unit suc_checker #(
  .CAPACITY (CAPACITY),
  .CNT_W    (CNT_W)
) u_suc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_count      (out_count),
  .out_colour_out (out_colour_out)
);
`default_nettype wire
